// ===== rtl/assert_macros.svh =====
// Assertion macros used by the tracker core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tmmt_pkg.sv =====
// Types, constants and unit conversion functions for the temperature tracker.
package tmmt_pkg;

  localparam int unsigned COUNT_W = 4;
  localparam logic [COUNT_W-1:0] PUBLISH_PERIOD = COUNT_W'(10);
  localparam logic [7:0] WARMUP_VALUE = 8'd85;
  localparam logic [7:0] FAHR_OFFSET  = 8'd32;

  // floor(x/5) == (x * 3277) >> 14 for x < 16384
  localparam logic [23:0] RECIP_5 = 24'd3277;
  // floor(x/9) == (x * 7282) >> 16 for x < 32768
  localparam logic [23:0] RECIP_9 = 24'd7282;

  typedef enum logic {
    OP_READING = 1'b0,
    OP_TOGGLE  = 1'b1
  } op_t;

  typedef struct packed {
    op_t         opcode;
    logic [15:0] raw_reading;
  } item_t;

  typedef struct packed {
    logic [7:0] current_temp;
    logic [7:0] published_low;
    logic [7:0] published_high;
    logic       unit_is_f;
    logic       tracking;
  } result_t;

  // 9c/5 + 32, rounded to nearest, saturating at 255
  function automatic logic [7:0] to_fahr(input logic [7:0] c);
    logic [11:0] x;
    logic [23:0] p;
    logic [9:0]  f;
    x = 12'(c) * 12'd9 + 12'd2;
    p = 24'(x) * RECIP_5;
    f = p[23:14] + 10'(FAHR_OFFSET);
    return (f > 10'd255) ? 8'hFF : f[7:0];
  endfunction

  // 5(f-32)/9, rounded to nearest, clamped at 0
  function automatic logic [7:0] to_cels(input logic [7:0] f);
    logic [7:0]  d;
    logic [10:0] x;
    logic [23:0] p;
    d = f - FAHR_OFFSET;
    x = 11'(d) * 11'd5 + 11'd4;
    p = 24'(x) * RECIP_9;
    return (f < FAHR_OFFSET) ? 8'd0 : p[23:16];
  endfunction

  function automatic logic [7:0] convert(input logic [7:0] v, input logic to_f);
    return to_f ? to_fahr(v) : to_cels(v);
  endfunction

endpackage

// ===== rtl/tmmt_core.sv =====
// Tracker state and its combinational update for one transfer.
`include "assert_macros.svh"

module tmmt_core
  import tmmt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  item_t   item,
  output result_t res
);

  logic [7:0]         current_value, current_value_next;
  logic [7:0]         running_low, running_low_next;
  logic [7:0]         running_high, running_high_next;
  logic [7:0]         shown_low, shown_low_next;
  logic [7:0]         shown_high, shown_high_next;
  logic [COUNT_W-1:0] reading_count, reading_count_next;
  logic               initialized, initialized_next;
  logic               warmed_up, warmed_up_next;
  logic               fahrenheit_mode, fahrenheit_mode_next;

  logic [7:0]         temp;
  logic [7:0]         low_upd, high_upd;
  logic [COUNT_W-1:0] count_inc;

  always_comb begin
    temp = fahrenheit_mode ? to_fahr(item.raw_reading[11:4]) : item.raw_reading[11:4];
    count_inc = reading_count + COUNT_W'(1);
    low_upd  = (temp < running_low)  ? temp : running_low;
    high_upd = (temp > running_high) ? temp : running_high;

    current_value_next   = current_value;
    running_low_next     = running_low;
    running_high_next    = running_high;
    shown_low_next       = shown_low;
    shown_high_next      = shown_high;
    reading_count_next   = reading_count;
    initialized_next     = initialized;
    warmed_up_next       = warmed_up;
    fahrenheit_mode_next = fahrenheit_mode;

    if (item.opcode == OP_TOGGLE) begin
      fahrenheit_mode_next = !fahrenheit_mode;
      current_value_next   = convert(current_value, !fahrenheit_mode);
      running_low_next     = convert(running_low, !fahrenheit_mode);
      running_high_next    = convert(running_high, !fahrenheit_mode);
      shown_low_next       = convert(shown_low, !fahrenheit_mode);
      shown_high_next      = convert(shown_high, !fahrenheit_mode);
    end else begin
      current_value_next = temp;
      if (!warmed_up) begin
        if (temp != WARMUP_VALUE) begin
          warmed_up_next     = 1'b1;
          initialized_next   = 1'b0;
          reading_count_next = '0;
        end
      end else begin
        if (!initialized) begin
          low_upd          = temp;
          high_upd         = temp;
          shown_low_next   = temp;
          shown_high_next  = temp;
          initialized_next = 1'b1;
        end
        running_low_next  = low_upd;
        running_high_next = high_upd;
        if (count_inc == PUBLISH_PERIOD) begin
          shown_low_next     = low_upd;
          shown_high_next    = high_upd;
          reading_count_next = '0;
        end else begin
          reading_count_next = count_inc;
        end
      end
    end

    res.current_temp   = current_value_next;
    res.published_low  = shown_low_next;
    res.published_high = shown_high_next;
    res.unit_is_f      = fahrenheit_mode_next;
    res.tracking       = warmed_up_next & initialized_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_value   <= '0;
      running_low     <= '0;
      running_high    <= '0;
      shown_low       <= '0;
      shown_high      <= '0;
      reading_count   <= '0;
      initialized     <= 1'b0;
      warmed_up       <= 1'b0;
      fahrenheit_mode <= 1'b0;
    end else if (en) begin
      current_value   <= current_value_next;
      running_low     <= running_low_next;
      running_high    <= running_high_next;
      shown_low       <= shown_low_next;
      shown_high      <= shown_high_next;
      reading_count   <= reading_count_next;
      initialized     <= initialized_next;
      warmed_up       <= warmed_up_next;
      fahrenheit_mode <= fahrenheit_mode_next;
    end
  end

  `ASSERT_ALWAYS(a_init_after_warm, clk, rst, !initialized || warmed_up, "initialised before warm-up")
  `ASSERT_ALWAYS(a_run_order, clk, rst, !initialized || (running_low <= running_high), "running min above max")
  `ASSERT_ALWAYS(a_shown_order, clk, rst, !initialized || (shown_low <= shown_high), "published min above max")
  `ASSERT_ALWAYS(a_count_range, clk, rst, reading_count < PUBLISH_PERIOD, "reading count overran period")
  `ASSERT_NEXT(a_toggle, clk, rst, en && (item.opcode == OP_TOGGLE), fahrenheit_mode != $past(fahrenheit_mode), "toggle did not flip unit")

endmodule

// ===== rtl/temperature_min_max_tracker.sv =====
// Top level of the temperature min/max tracker: input register, core, result register.
//
// Input channel item (item_valid / item_stall): a sensor reading or a unit toggle.
// Output channel result (result_valid / result_stall): one result per input transfer,
// carrying the latest temperature, the published min/max, the unit and tracking flag.
// An item transfers on a rising edge with valid high and stall low.
// An item taken into the input register is processed when it advances into the result
// register, and its result is offered from then on. One item is taken per cycle while
// result_stall is low, as the core updates its state combinationally.
// The input register and the result register let a new item be taken while a finished
// result still waits for the receiver.
// When result_stall is held the result holds, the input register fills and item_stall
// rises; nothing is dropped.
// Reset (rst, synchronous, active high) empties both registers and returns all
// temperatures, counts and flags to zero in Celsius, warm-up pending.
module temperature_min_max_tracker
  import tmmt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic    in_full;
  item_t   in_item;
  logic    advance;
  logic    take;
  result_t core_res;

  assign advance    = in_full && (!result_valid || !result_stall);
  assign item_stall = in_full && result_valid && result_stall;
  assign take       = item_valid && !item_stall;

  tmmt_core u_core (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .item (in_item),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      in_full <= take || (in_full && !advance);
      if (advance) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
    if (take) begin
      in_item <= item;
    end
    if (advance) begin
      result <= core_res;
    end
  end

endmodule
